FILE: design/gda_pkg.sv
// Package with shared types, codes, constants and calendar tables for the date unit.
package gda_pkg;

  localparam int unsigned DEFAULT_MAX_YEAR = 9999;
  localparam int unsigned YEAR_FIELD_TOP   = 16383;
  localparam int          DIFF_SAT         = 4194303;

  localparam logic [1:0] OP_ADD   = 2'd0;
  localparam logic [1:0] OP_DIFF  = 2'd1;
  localparam logic [1:0] OP_CMP   = 2'd2;
  localparam logic [1:0] OP_CHECK = 2'd3;

  localparam logic [1:0] ORD_BEFORE = 2'd0;
  localparam logic [1:0] ORD_EQUAL  = 2'd1;
  localparam logic [1:0] ORD_AFTER  = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIV_A,
    ST_SER_A,
    ST_DIV_B,
    ST_SER_B,
    ST_EVAL,
    ST_DIV_ERA,
    ST_DIV_1460,
    ST_ADJ,
    ST_DIV_365,
    ST_SPLIT,
    ST_MONTH,
    ST_DONE
  } gda_state_t;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

  // First day of each month counted from March 1st.
  function automatic logic [8:0] mp_start(input logic [3:0] mp);
    logic [8:0] s;
    unique case (mp)
      4'd0:    s = 9'd0;
      4'd1:    s = 9'd31;
      4'd2:    s = 9'd61;
      4'd3:    s = 9'd92;
      4'd4:    s = 9'd122;
      4'd5:    s = 9'd153;
      4'd6:    s = 9'd184;
      4'd7:    s = 9'd214;
      4'd8:    s = 9'd245;
      4'd9:    s = 9'd275;
      4'd10:   s = 9'd306;
      4'd11:   s = 9'd337;
      default: s = 9'd0;
    endcase
    return s;
  endfunction

  function automatic logic [8:0] month_start(input logic [3:0] m);
    logic [3:0] mp;
    mp = (m > 4'd2) ? 4'(m - 4'd3) : 4'(m + 4'd9);
    return mp_start(mp);
  endfunction

endpackage

FILE: design/gregorian_date_arithmetic.sv
// Top level of the Gregorian date unit: add days, difference, compare and validate.
//
//   Channel   Ports                          Handshake
//   input     in_opcode .. in_day_offset     start high while busy low
//   result    out_res_year .. out_range_error out_valid high for one cycle
//
// A transaction is taken when start is high and busy is low. Every operation runs two
// 8-step divisions of the years by 100 on the shared restoring subtractor, forms each day
// serial (SER_A, SER_B), evaluates (EVAL) and then raises the result strobe (DONE). An add
// of a valid date that lands in range then splits the serial with three more divisions
// (6, 7 and 9 steps) and the ADJ, SPLIT and MONTH states before the strobe. busy stays
// high until the strobe cycle ends. Reset is synchronous and returns the sequencer to idle;
// results are presented for exactly one cycle and cannot be held off by the receiver.
module gregorian_date_arithmetic import gda_pkg::*; #(
  parameter int unsigned MAX_YEAR = DEFAULT_MAX_YEAR
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_opcode,
  input  logic [13:0]        in_year_a,
  input  logic [3:0]         in_month_a,
  input  logic [4:0]         in_day_a,
  input  logic [13:0]        in_year_b,
  input  logic [3:0]         in_month_b,
  input  logic [4:0]         in_day_b,
  input  logic signed [20:0] in_day_offset,
  output logic               out_valid,
  output logic [13:0]        out_res_year,
  output logic [3:0]         out_res_month,
  output logic [4:0]         out_res_day,
  output logic signed [22:0] out_day_difference,
  output logic [1:0]         out_order,
  output logic               out_leap_flag,
  output logic               out_input_invalid,
  output logic               out_range_error
);

  localparam int unsigned YearTop  = (MAX_YEAR < YEAR_FIELD_TOP) ? MAX_YEAR : YEAR_FIELD_TOP;
  localparam int unsigned TopEra   = YearTop / 400;
  localparam int unsigned TopYoe   = YearTop - TopEra * 400;
  localparam int unsigned TopDoe   = TopYoe * 365 + TopYoe / 4 - TopYoe / 100 + 305;
  localparam int unsigned SerialHi = TopEra * 146097 + TopDoe;

  localparam logic [13:0]        YearTopW = 14'(YearTop);
  localparam logic signed [24:0] SerLoS   = 25'sd306;
  localparam logic signed [24:0] SerHiS   = 25'(SerialHi);
  localparam logic signed [23:0] SatPos   = 24'(DIFF_SAT);
  localparam logic signed [23:0] SatNeg   = -24'(DIFF_SAT);

  localparam logic [23:0] DivCent  = 24'd100;
  localparam logic [23:0] DivEra   = 24'd146097;
  localparam logic [23:0] DivGroup = 24'd1460;
  localparam logic [23:0] DivDays  = 24'd365;

  localparam logic [3:0] CntCent  = 4'd7;
  localparam logic [3:0] CntEra   = 4'd5;
  localparam logic [3:0] CntGroup = 4'd6;
  localparam logic [3:0] CntDays  = 4'd8;

  gda_state_t state_r, state_nxt;

  logic [1:0]         op_r, op_nxt;
  logic [13:0]        ya_r, ya_nxt, yb_r, yb_nxt;
  logic [3:0]         ma_r, ma_nxt, mb_r, mb_nxt;
  logic [4:0]         da_r, da_nxt, db_r, db_nxt;
  logic signed [20:0] off_r, off_nxt;

  logic [23:0] rem_r, rem_nxt;
  logic [8:0]  quo_r, quo_nxt;
  logic [3:0]  cnt_r, cnt_nxt;

  logic [22:0] ser_a_r, ser_a_nxt, ser_b_r, ser_b_nxt;
  logic        valid_a_r, valid_a_nxt, valid_b_r, valid_b_nxt;
  logic        leap_a_r, leap_a_nxt;

  logic [5:0]  era_r, era_nxt;
  logic [17:0] doe_r, doe_nxt;
  logic [6:0]  grp_r, grp_nxt;
  logic [8:0]  yoe_r, yoe_nxt;
  logic [8:0]  doy_r, doy_nxt;

  logic [13:0]        res_year_r, res_year_nxt;
  logic [3:0]         res_month_r, res_month_nxt;
  logic [4:0]         res_day_r, res_day_nxt;
  logic signed [22:0] diff_r, diff_nxt;
  logic [1:0]         order_r, order_nxt;
  logic               leap_r, leap_nxt;
  logic               invalid_r, invalid_nxt;
  logic               rerr_r, rerr_nxt;

  // Shared restoring divider step.
  logic [23:0] div_d;
  logic [23:0] div_shift;
  logic [24:0] div_diff;
  logic        div_take;
  logic [23:0] fin_rem;
  logic [8:0]  fin_quo;

  always_comb begin
    unique case (state_r)
      ST_DIV_ERA:  div_d = DivEra;
      ST_DIV_1460: div_d = DivGroup;
      ST_DIV_365:  div_d = DivDays;
      default:     div_d = DivCent;
    endcase
    div_shift = div_d << cnt_r;
    div_diff  = {1'b0, rem_r} - {1'b0, div_shift};
    div_take  = ~div_diff[24];
    fin_rem   = div_take ? div_diff[23:0] : rem_r;
    fin_quo   = div_take ? (quo_r | (9'd1 << cnt_r)) : quo_r;
  end

  // Date to day serial, from the year split by 100.
  logic        sel_b;
  logic [13:0] ys;
  logic [3:0]  ms;
  logic [4:0]  ds;
  logic [6:0]  r7, rr;
  logic [7:0]  q8, qq;
  logic        leap_x, valid_x;
  logic [4:0]  mlen;
  logic [8:0]  doy_x;
  logic [22:0] ser_x;

  always_comb begin
    sel_b  = (state_r == ST_SER_B);
    ys     = sel_b ? yb_r : ya_r;
    ms     = sel_b ? mb_r : ma_r;
    ds     = sel_b ? db_r : da_r;
    r7     = rem_r[6:0];
    q8     = quo_r[7:0];
    leap_x = ((ys[1:0] == 2'b00) && (r7 != 7'd0)) || ((r7 == 7'd0) && (q8[1:0] == 2'b00));
    mlen   = month_len(ms, leap_x);
    valid_x = (ys != 14'd0) && (ys <= YearTopW) && (ms >= 4'd1) && (ms <= 4'd12) &&
              (ds != 5'd0) && (ds <= mlen);
    if (ms <= 4'd2) begin
      if (r7 != 7'd0) begin
        qq = q8;
        rr = 7'(r7 - 7'd1);
      end else begin
        qq = 8'(q8 - 8'd1);
        rr = 7'd99;
      end
    end else begin
      qq = q8;
      rr = r7;
    end
    doy_x = 9'(month_start(ms) + 9'(ds) - 9'd1);
    ser_x = 23'(23'(qq) * 23'd36524 + 23'(qq >> 2) + 23'(rr) * 23'd365 + 23'(rr >> 2) +
                23'(doy_x));
  end

  // Evaluation of range, difference and order.
  logic signed [24:0] s_sum;
  logic               in_range;
  logic signed [23:0] diff_full;
  logic signed [22:0] diff_sat;
  logic               sat_flag;
  logic [1:0]         order_x;
  logic               go_date;

  always_comb begin
    s_sum     = $signed({2'b00, ser_a_r}) + 25'(off_r);
    in_range  = (s_sum >= SerLoS) && (s_sum <= SerHiS);
    diff_full = $signed({1'b0, ser_a_r}) - $signed({1'b0, ser_b_r});
    if (diff_full > SatPos) begin
      diff_sat = 23'(SatPos);
      sat_flag = 1'b1;
    end else if (diff_full < SatNeg) begin
      diff_sat = 23'(SatNeg);
      sat_flag = 1'b1;
    end else begin
      diff_sat = 23'(diff_full);
      sat_flag = 1'b0;
    end
    if (ya_r != yb_r) begin
      order_x = (ya_r < yb_r) ? ORD_BEFORE : ORD_AFTER;
    end else if (ma_r != mb_r) begin
      order_x = (ma_r < mb_r) ? ORD_BEFORE : ORD_AFTER;
    end else if (da_r != db_r) begin
      order_x = (da_r < db_r) ? ORD_BEFORE : ORD_AFTER;
    end else begin
      order_x = ORD_EQUAL;
    end
    go_date = (op_r == OP_ADD) && valid_a_r && in_range;
  end

  // Serial to date, after the era and four-year splits.
  logic [2:0]  cent_x;
  logic        last_x;
  logic [17:0] t_x;
  logic [1:0]  yc_x;
  logic [17:0] base_x;
  logic [3:0]  mp_x;
  logic [3:0]  mm_x;

  always_comb begin
    cent_x = 3'(doe_r >= 18'd36524) + 3'(doe_r >= 18'd73048) + 3'(doe_r >= 18'd109572) +
             3'(doe_r >= 18'd146096);
    last_x = (doe_r == 18'd146096);
    t_x    = 18'(doe_r - 18'(grp_r) + 18'(cent_x) - 18'(last_x));
    yc_x   = 2'(yoe_r >= 9'd100) + 2'(yoe_r >= 9'd200) + 2'(yoe_r >= 9'd300);
    base_x = 18'(18'(yoe_r) * 18'd365 + 18'(yoe_r >> 2) - 18'(yc_x));
    mp_x   = 4'd0;
    for (int i = 1; i < 12; i++) begin
      if (doy_r >= mp_start(4'(i))) begin
        mp_x = 4'(i);
      end
    end
    mm_x = (mp_x < 4'd10) ? 4'(mp_x + 4'd3) : 4'(mp_x - 4'd9);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:     if (start) state_nxt = ST_DIV_A;
      ST_DIV_A:    if (cnt_r == 4'd0) state_nxt = ST_SER_A;
      ST_SER_A:    state_nxt = ST_DIV_B;
      ST_DIV_B:    if (cnt_r == 4'd0) state_nxt = ST_SER_B;
      ST_SER_B:    state_nxt = ST_EVAL;
      ST_EVAL:     state_nxt = go_date ? ST_DIV_ERA : ST_DONE;
      ST_DIV_ERA:  if (cnt_r == 4'd0) state_nxt = ST_DIV_1460;
      ST_DIV_1460: if (cnt_r == 4'd0) state_nxt = ST_ADJ;
      ST_ADJ:      state_nxt = ST_DIV_365;
      ST_DIV_365:  if (cnt_r == 4'd0) state_nxt = ST_SPLIT;
      ST_SPLIT:    state_nxt = ST_MONTH;
      ST_MONTH:    state_nxt = ST_DONE;
      ST_DONE:     state_nxt = ST_IDLE;
      default:     state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    busy      = (state_r != ST_IDLE);
    out_valid = (state_r == ST_DONE);
  end

  always_comb begin
    op_nxt  = op_r;
    ya_nxt  = ya_r;
    ma_nxt  = ma_r;
    da_nxt  = da_r;
    yb_nxt  = yb_r;
    mb_nxt  = mb_r;
    db_nxt  = db_r;
    off_nxt = off_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    ser_a_nxt   = ser_a_r;
    ser_b_nxt   = ser_b_r;
    valid_a_nxt = valid_a_r;
    valid_b_nxt = valid_b_r;
    leap_a_nxt  = leap_a_r;
    era_nxt = era_r;
    doe_nxt = doe_r;
    grp_nxt = grp_r;
    yoe_nxt = yoe_r;
    doy_nxt = doy_r;
    res_year_nxt  = res_year_r;
    res_month_nxt = res_month_r;
    res_day_nxt   = res_day_r;
    diff_nxt      = diff_r;
    order_nxt     = order_r;
    leap_nxt      = leap_r;
    invalid_nxt   = invalid_r;
    rerr_nxt      = rerr_r;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          op_nxt  = in_opcode;
          ya_nxt  = in_year_a;
          ma_nxt  = in_month_a;
          da_nxt  = in_day_a;
          yb_nxt  = in_year_b;
          mb_nxt  = in_month_b;
          db_nxt  = in_day_b;
          off_nxt = in_day_offset;
          rem_nxt = 24'(in_year_a);
          quo_nxt = 9'd0;
          cnt_nxt = CntCent;
        end
      end
      ST_DIV_A, ST_DIV_B, ST_DIV_365: begin
        rem_nxt = fin_rem;
        quo_nxt = fin_quo;
        cnt_nxt = 4'(cnt_r - 4'd1);
        if ((state_r == ST_DIV_365) && (cnt_r == 4'd0)) begin
          yoe_nxt = fin_quo;
        end
      end
      ST_SER_A: begin
        ser_a_nxt   = ser_x;
        valid_a_nxt = valid_x;
        leap_a_nxt  = leap_x;
        rem_nxt     = 24'(yb_r);
        quo_nxt     = 9'd0;
        cnt_nxt     = CntCent;
      end
      ST_SER_B: begin
        ser_b_nxt   = ser_x;
        valid_b_nxt = valid_x;
      end
      ST_EVAL: begin
        res_year_nxt  = ya_r;
        res_month_nxt = ma_r;
        res_day_nxt   = da_r;
        diff_nxt      = 23'sd0;
        order_nxt     = order_x;
        leap_nxt      = leap_a_r;
        invalid_nxt   = 1'b0;
        rerr_nxt      = 1'b0;
        unique case (op_r)
          OP_ADD: begin
            if (!valid_a_r) begin
              invalid_nxt = 1'b1;
            end else if (!in_range) begin
              rerr_nxt = 1'b1;
            end
          end
          OP_DIFF: begin
            if (!valid_a_r || !valid_b_r) begin
              invalid_nxt = 1'b1;
            end else begin
              diff_nxt = diff_sat;
              rerr_nxt = sat_flag;
            end
          end
          OP_CMP:   invalid_nxt = !valid_a_r || !valid_b_r;
          OP_CHECK: invalid_nxt = !valid_a_r;
          default:  invalid_nxt = 1'b0;
        endcase
        rem_nxt = 24'(s_sum);
        quo_nxt = 9'd0;
        cnt_nxt = CntEra;
      end
      ST_DIV_ERA: begin
        rem_nxt = fin_rem;
        quo_nxt = fin_quo;
        cnt_nxt = 4'(cnt_r - 4'd1);
        if (cnt_r == 4'd0) begin
          era_nxt = fin_quo[5:0];
          doe_nxt = fin_rem[17:0];
          quo_nxt = 9'd0;
          cnt_nxt = CntGroup;
        end
      end
      ST_DIV_1460: begin
        rem_nxt = fin_rem;
        quo_nxt = fin_quo;
        cnt_nxt = 4'(cnt_r - 4'd1);
        if (cnt_r == 4'd0) begin
          grp_nxt = fin_quo[6:0];
        end
      end
      ST_ADJ: begin
        rem_nxt = 24'(t_x);
        quo_nxt = 9'd0;
        cnt_nxt = CntDays;
      end
      ST_SPLIT: begin
        doy_nxt = 9'(doe_r - base_x);
      end
      ST_MONTH: begin
        res_month_nxt = mm_x;
        res_day_nxt   = 5'(doy_r - mp_start(mp_x) + 9'd1);
        res_year_nxt  = 14'(14'(yoe_r) + 14'(era_r) * 14'd400 + 14'(mm_x <= 4'd2));
      end
      default: begin
        op_nxt = op_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ya_r        <= ya_nxt;
    ma_r        <= ma_nxt;
    da_r        <= da_nxt;
    yb_r        <= yb_nxt;
    mb_r        <= mb_nxt;
    db_r        <= db_nxt;
    off_r       <= off_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    ser_a_r     <= ser_a_nxt;
    ser_b_r     <= ser_b_nxt;
    valid_a_r   <= valid_a_nxt;
    valid_b_r   <= valid_b_nxt;
    leap_a_r    <= leap_a_nxt;
    era_r       <= era_nxt;
    doe_r       <= doe_nxt;
    grp_r       <= grp_nxt;
    yoe_r       <= yoe_nxt;
    doy_r       <= doy_nxt;
    res_year_r  <= res_year_nxt;
    res_month_r <= res_month_nxt;
    res_day_r   <= res_day_nxt;
    diff_r      <= diff_nxt;
    order_r     <= order_nxt;
    leap_r      <= leap_nxt;
    invalid_r   <= invalid_nxt;
    rerr_r      <= rerr_nxt;
  end

  assign out_res_year       = res_year_r;
  assign out_res_month      = res_month_r;
  assign out_res_day        = res_day_r;
  assign out_day_difference = diff_r;
  assign out_order          = order_r;
  assign out_leap_flag      = leap_r;
  assign out_input_invalid  = invalid_r;
  assign out_range_error    = rerr_r;

endmodule
